[sv/stable_priority_queue_assert.svh]
// Assertion macros used by the checker of the stable priority queue.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spq assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spq assertion failed");

`endif

[sv/spq_pkg.sv]
// Package for the stable priority queue: sizes, operation codes and the
// entry and command types passed along the cell chain. No dependencies.
`default_nettype none

package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int PRI_W    = 8;
    localparam int PAY_W    = 32;
    localparam int KIND_W   = 2;

    typedef enum logic [KIND_W-1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_PEEK = 2'd2,
        OP_NOP  = 2'd3
    } op_kind_t;

    // One slot of the sorted list
    typedef struct packed {
        logic             valid;
        logic [PRI_W-1:0] pri;
        logic [PAY_W-1:0] pay;
    } entry_t;

    // Operation broadcast to every cell
    typedef struct packed {
        logic             enq;
        logic             deq;
        logic [PRI_W-1:0] pri;
        logic [PAY_W-1:0] pay;
    } cell_cmd_t;

endpackage

`default_nettype wire

[sv/spq_if.sv]
// Channel interfaces of the stable priority queue: request and response.
// Depends on spq_pkg for field widths.
`default_nettype none

interface spq_req_if import spq_pkg::*;;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [PRI_W-1:0]  priority_req;
    logic [PAY_W-1:0]  payload;

    modport source (output valid, kind, priority_req, payload, input ready);
    modport sink   (input valid, kind, priority_req, payload, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*;;
    logic             valid;
    logic             ready;
    logic             ok;
    logic             is_empty;
    logic [PRI_W-1:0] head_priority;
    logic [PAY_W-1:0] head_payload;

    modport source (output valid, ok, is_empty, head_priority, head_payload, input ready);
    modport sink   (input valid, ok, is_empty, head_priority, head_payload, output ready);
endinterface

`default_nettype wire

[sv/spq_cell.sv]
// One slot of the sorted chain: holds an entry and, on each operation,
// keeps it, takes the new entry, or takes a neighbor's entry. Uses spq_pkg.
`default_nettype none

module spq_cell import spq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_cmd_t cmd,
    input  wire entry_t    left,
    input  wire logic      left_keep,
    input  wire entry_t    right,
    output      entry_t    slot,
    output      logic      keep
);

    logic             valid_reg;
    logic             valid_next;
    logic [PRI_W-1:0] pri_reg;
    logic [PRI_W-1:0] pri_next;
    logic [PAY_W-1:0] pay_reg;
    logic [PAY_W-1:0] pay_next;

    // Stay in place when this entry ranks at or above the new one
    assign keep = valid_reg && (pri_reg >= cmd.pri);

    // Pick hold, insert, shift toward tail, or shift toward head
    always_comb
    begin
        valid_next = valid_reg;
        pri_next   = pri_reg;
        pay_next   = pay_reg;
        if (cmd.enq)
        begin
            if (!keep)
            begin
                if (left_keep)
                begin
                    valid_next = 1'b1;
                    pri_next   = cmd.pri;
                    pay_next   = cmd.pay;
                end
                else
                begin
                    valid_next = left.valid;
                    pri_next   = left.pri;
                    pay_next   = left.pay;
                end
            end
        end
        else if (cmd.deq)
        begin
            valid_next = right.valid;
            pri_next   = right.pri;
            pay_next   = right.pay;
        end
    end

    // Occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Entry data
    always_ff @(posedge clk)
    begin
        pri_reg <= pri_next;
        pay_reg <= pay_next;
    end

    assign slot = '{valid: valid_reg, pri: pri_reg, pay: pay_reg};

endmodule

`default_nettype wire

[sv/stable_priority_queue.sv]
// Stable priority queue: a chain of CAPACITY cells kept sorted, highest first.
// Latency: a result appears in the cycle after its request word is accepted.
// Throughput: one operation per cycle; all cells compare and shift in parallel.
// A stalled response holds off new requests (single output register).
// Reset (rst_n, async, active low) empties the queue and drops any pending response.
`default_nettype none

module stable_priority_queue import spq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    entry_t    slot   [CAPACITY];
    logic      keep   [CAPACITY];
    cell_cmd_t cmd;
    op_kind_t  kind;
    logic      accept;
    logic      full;
    logic      empty;

    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    logic             ok_reg;
    logic             ok_next;
    logic             is_empty_reg;
    logic             is_empty_next;
    logic [PRI_W-1:0] head_pri_reg;
    logic [PRI_W-1:0] head_pri_next;
    logic [PAY_W-1:0] head_pay_reg;
    logic [PAY_W-1:0] head_pay_next;

    // Take a request word whenever the response register is free or draining
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign kind      = op_kind_t'(req.kind);
    assign full      = slot[CAPACITY-1].valid;
    assign empty     = !slot[0].valid;

    // Broadcast the operation; drop enqueue when full and dequeue when empty
    always_comb
    begin
        cmd.enq = accept && (kind == OP_ENQ) && !full;
        cmd.deq = accept && (kind == OP_DEQ) && !empty;
        cmd.pri = req.priority_req;
        cmd.pay = req.payload;
    end

    // Chain of cells, head at index zero
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t left_e;
        entry_t right_e;
        logic   left_k;

        if (i == 0)
        begin : g_head
            assign left_e = '0;
            assign left_k = 1'b1;
        end
        else
        begin : g_body
            assign left_e = slot[i-1];
            assign left_k = keep[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_e = '0;
        end
        else
        begin : g_inner
            assign right_e = slot[i+1];
        end

        spq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .left      (left_e),
            .left_keep (left_k),
            .right     (right_e),
            .slot      (slot[i]),
            .keep      (keep[i])
        );
    end

    // Form the response word
    always_comb
    begin
        ok_next       = 1'b0;
        is_empty_next = empty;
        head_pri_next = '0;
        head_pay_next = '0;
        unique case (kind)
            OP_ENQ:
            begin
                ok_next = !full;
                if (!full)
                    is_empty_next = 1'b0;
            end
            OP_DEQ:
            begin
                ok_next = !empty;
                if (!empty)
                    is_empty_next = !slot[1].valid;
            end
            OP_PEEK:
            begin
                ok_next = !empty;
                if (!empty)
                begin
                    head_pri_next = slot[0].pri;
                    head_pay_next = slot[0].pay;
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    // Response valid: set on accept, clear when taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    // Response payload: load on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg       <= ok_next;
            is_empty_reg <= is_empty_next;
            head_pri_reg <= head_pri_next;
            head_pay_reg <= head_pay_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.ok            = ok_reg;
    assign rsp.is_empty      = is_empty_reg;
    assign rsp.head_priority = head_pri_reg;
    assign rsp.head_payload  = head_pay_reg;

endmodule

`default_nettype wire

[sv/spq_checker.sv]
// Port-level checker for the stable priority queue, bound to the top level.
// Uses spq_pkg and the macros of stable_priority_queue_assert.svh.
`default_nettype none
`include "stable_priority_queue_assert.svh"

module spq_checker import spq_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             req_valid,
    input wire logic             req_ready,
    input wire logic             rsp_valid,
    input wire logic             rsp_ready,
    input wire logic             rsp_ok,
    input wire logic             rsp_is_empty,
    input wire logic [PRI_W-1:0] rsp_head_priority,
    input wire logic [PAY_W-1:0] rsp_head_payload
);

    // Every accepted request yields a response word in the next cycle
    `SPQ_ASSERT_NEXT(a_rsp_follows_req, req_valid && req_ready, rsp_valid)

    // A stalled response blocks new requests
    `SPQ_ASSERT_SAME(a_stall_blocks_req, rsp_valid && !rsp_ready, !req_ready)

    // An empty queue after the operation cannot report a head
    `SPQ_ASSERT_SAME(a_empty_no_head, rsp_valid && rsp_is_empty,
        rsp_head_priority == '0 && rsp_head_payload == '0)

    // A stalled response word holds its ok and is_empty flags
    `SPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_ok) && $stable(rsp_is_empty))

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_ok            (rsp.ok),
    .rsp_is_empty      (rsp.is_empty),
    .rsp_head_priority (rsp.head_priority),
    .rsp_head_payload  (rsp.head_payload)
);

`default_nettype wire

[tb/stable_priority_queue_tb.sv]
// Testbench for stable_priority_queue: drives enqueue, dequeue, peek and unused
// operation words and checks every response against a typed row or a sorted-list shadow queue.
// Depends on spq_pkg, spq_if.sv and the RTL of the block.
`default_nettype none

module stable_priority_queue_tb;
    import spq_pkg::*;

    localparam int DIRECTED_ROWS = 26;
    localparam int RANDOM_ITEMS  = 400;
    localparam int HOLDOFF_LEN   = 60;

    // Response word as seen on the rsp channel
    typedef struct packed {
        logic             ok;
        logic             is_empty;
        logic [PRI_W-1:0] head_priority;
        logic [PAY_W-1:0] head_payload;
    } pq_result_t;

    // One directed row: the operation, then a typed response where known
    typedef struct packed {
        op_kind_t         kind;
        logic [PRI_W-1:0] pri;
        logic [PAY_W-1:0] pay;
        logic             typed;
        logic             ok;
        logic             is_empty;
        logic [PRI_W-1:0] head_priority;
        logic [PAY_W-1:0] head_payload;
    } op_row_t;

    logic clk;
    logic rst_n;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    stable_priority_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow of the sorted list, head at slot 0
    logic [PRI_W-1:0] sorted_pri [CAPACITY];
    logic [PAY_W-1:0] sorted_pay [CAPACITY];
    int               fill_level;

    pq_result_t pending_results [$];
    int         fail_count;
    int         results_checked;

    // Coverage tallies for the closing summary
    int enq_done, enq_refused, deq_done, deq_refused;
    int peek_hit, peek_refused, nop_count, deepest;

    op_row_t directed_rows [DIRECTED_ROWS] = '{
        // empty queue: every read fails, unused code is a no-op
        '{OP_PEEK, 8'h00, 32'h0000_0000, 1'b1, 1'b0, 1'b1, 8'h00, 32'h0000_0000},
        '{OP_DEQ,  8'hff, 32'hffff_ffff, 1'b1, 1'b0, 1'b1, 8'h00, 32'h0000_0000},
        '{OP_NOP,  8'hff, 32'hffff_ffff, 1'b1, 1'b0, 1'b1, 8'h00, 32'h0000_0000},
        // field extremes
        '{OP_ENQ,  8'h00, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 8'h00, 32'h0000_0000},
        '{OP_ENQ,  8'hff, 32'hffff_ffff, 1'b1, 1'b1, 1'b0, 8'h00, 32'h0000_0000},
        '{OP_PEEK, 8'h00, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 8'hff, 32'hffff_ffff},
        // tie at the top must queue behind the earlier entry
        '{OP_ENQ,  8'hff, 32'h0000_0001, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0000_0000},
        '{OP_ENQ,  8'h80, 32'haaaa_aaaa, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0000_0000},
        '{OP_DEQ,  8'h00, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0000_0000},
        '{OP_PEEK, 8'h00, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0000_0000},
        // unused code on a non-empty queue
        '{OP_NOP,  8'h5a, 32'h5555_5555, 1'b1, 1'b0, 1'b0, 8'h00, 32'h0000_0000},
        // fill to capacity with ties scattered through the list
        '{OP_ENQ,  8'h80, 32'h0000_0100, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0000_0000},
        '{OP_ENQ,  8'h07, 32'h0000_0101, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0000_0000},
        '{OP_ENQ,  8'hff, 32'h0000_0102, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0000_0000},
        '{OP_ENQ,  8'h80, 32'h0000_0103, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0000_0000},
        '{OP_ENQ,  8'h00, 32'h0000_0104, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0000_0000},
        '{OP_ENQ,  8'h40, 32'h0000_0105, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0000_0000},
        '{OP_ENQ,  8'hc8, 32'h0000_0106, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0000_0000},
        '{OP_ENQ,  8'h80, 32'h0000_0107, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0000_0000},
        '{OP_ENQ,  8'h01, 32'h0000_0108, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0000_0000},
        '{OP_ENQ,  8'hfe, 32'h0000_0109, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0000_0000},
        '{OP_ENQ,  8'h40, 32'h0000_010a, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0000_0000},
        '{OP_ENQ,  8'h07, 32'h0000_010b, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0000_0000},
        '{OP_ENQ,  8'h80, 32'h0000_010c, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0000_0000},
        // full: enqueue is refused, queue stays intact
        '{OP_ENQ,  8'hff, 32'hdead_beef, 1'b1, 1'b0, 1'b0, 8'h00, 32'h0000_0000},
        '{OP_PEEK, 8'h00, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00, 32'h0000_0000}
    };

    // Apply one operation to the shadow list and return its response
    function automatic pq_result_t queue_op_result(input op_kind_t kind,
                                                   input logic [PRI_W-1:0] pri,
                                                   input logic [PAY_W-1:0] pay);
        pq_result_t res;
        int         pos;
        res = '0;
        case (kind)
            OP_ENQ:
            begin
                if (fill_level < CAPACITY)
                begin
                    pos = 0;
                    while (pos < fill_level && sorted_pri[pos] >= pri)
                        pos++;
                    for (int i = fill_level; i > pos; i--)
                    begin
                        sorted_pri[i] = sorted_pri[i-1];
                        sorted_pay[i] = sorted_pay[i-1];
                    end
                    sorted_pri[pos] = pri;
                    sorted_pay[pos] = pay;
                    fill_level++;
                    res.ok = 1'b1;
                    enq_done++;
                end
                else
                    enq_refused++;
            end
            OP_DEQ:
            begin
                if (fill_level > 0)
                begin
                    for (int i = 1; i < fill_level; i++)
                    begin
                        sorted_pri[i-1] = sorted_pri[i];
                        sorted_pay[i-1] = sorted_pay[i];
                    end
                    fill_level--;
                    res.ok = 1'b1;
                    deq_done++;
                end
                else
                    deq_refused++;
            end
            OP_PEEK:
            begin
                if (fill_level > 0)
                begin
                    res.ok            = 1'b1;
                    res.head_priority = sorted_pri[0];
                    res.head_payload  = sorted_pay[0];
                    peek_hit++;
                end
                else
                    peek_refused++;
            end
            default:
                nop_count++;
        endcase
        res.is_empty = (fill_level == 0);
        if (fill_level > deepest)
            deepest = fill_level;
        return res;
    endfunction

    // Offer one word and hold it until accepted, then log its response
    task automatic send_op(input op_kind_t kind, input logic [PRI_W-1:0] pri,
                           input logic [PAY_W-1:0] pay, input logic typed,
                           input pq_result_t typed_result);
        pq_result_t predicted;
        req_ch.valid        <= 1'b1;
        req_ch.kind         <= kind;
        req_ch.priority_req <= pri;
        req_ch.payload      <= pay;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = queue_op_result(kind, pri, pay);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    // Drop valid and wait until every logged response has come back
    task automatic drain_pending();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("stable_priority_queue_tb: done, errors");
        $finish;
    end

    // Response side: check each word, stall on a pattern of its own
    initial
    begin : rsp_side
        pq_result_t got;
        pq_result_t want;
        int         mode;
        int         mode_left;
        int         holdoff_left;
        int         tick;
        rsp_ch.ready <= 1'b0;
        mode         = 0;
        mode_left    = 0;
        holdoff_left = 0;
        tick         = 0;
        forever
        begin
            @(posedge clk);
            // check an accepted word against the oldest logged response
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                got = {rsp_ch.ok, rsp_ch.is_empty, rsp_ch.head_priority, rsp_ch.head_payload};
                if (pending_results.size() == 0)
                begin
                    $error("response word with none pending: ok=%0d is_empty=%0d", got.ok,
                           got.is_empty);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.ok !== want.ok)
                    begin
                        $error("ok: expected %0d, actual %0d", want.ok, got.ok);
                        fail_count++;
                    end
                    if (got.is_empty !== want.is_empty)
                    begin
                        $error("is_empty: expected %0d, actual %0d", want.is_empty,
                               got.is_empty);
                        fail_count++;
                    end
                    if (got.head_priority !== want.head_priority)
                    begin
                        $error("head_priority: expected 0x%02h, actual 0x%02h",
                               want.head_priority, got.head_priority);
                        fail_count++;
                    end
                    if (got.head_payload !== want.head_payload)
                    begin
                        $error("head_payload: expected 0x%08h, actual 0x%08h",
                               want.head_payload, got.head_payload);
                        fail_count++;
                    end
                end
                results_checked++;
                // hold off twice for a long stretch so the request side backs up
                if (results_checked == 50 || results_checked == 300)
                    holdoff_left = HOLDOFF_LEN;
            end
            // pick the next stall pattern now and then
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(8, 40);
            end
            mode_left--;
            tick++;
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:       rsp_ch.ready <= (tick % 3 != 0);
                    default: rsp_ch.ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // Request side and run control
    initial
    begin : req_side
        op_kind_t         kind;
        logic [PRI_W-1:0] pri;
        int               burst_left;
        int               gap;
        int               pick;
        int               enq_weight;
        int               deq_weight;
        pq_result_t       typed_result;

        fail_count      = 0;
        results_checked = 0;
        fill_level      = 0;
        enq_done        = 0;
        enq_refused     = 0;
        deq_done        = 0;
        deq_refused     = 0;
        peek_hit        = 0;
        peek_refused    = 0;
        nop_count       = 0;
        deepest         = 0;
        burst_left      = 0;

        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.kind         <= OP_NOP;
        req_ch.priority_req <= '0;
        req_ch.payload      <= '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, with short random gaps
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 3))
                    @(posedge clk);
            end
            typed_result = {directed_rows[r].ok, directed_rows[r].is_empty,
                            directed_rows[r].head_priority, directed_rows[r].head_payload};
            send_op(directed_rows[r].kind, directed_rows[r].pri, directed_rows[r].pay,
                    directed_rows[r].typed, typed_result);
        end
        drain_pending();

        // random words in bursts; phases lean toward filling, draining or balance
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0)
                begin
                    req_ch.valid <= 1'b0;
                    repeat (gap)
                        @(posedge clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;

            // pause once midway until nothing is pending
            if (n == RANDOM_ITEMS / 2)
                drain_pending();

            case ((n / 40) % 3)
                0:
                begin
                    enq_weight = 60;
                    deq_weight = 20;
                end
                1:
                begin
                    enq_weight = 20;
                    deq_weight = 60;
                end
                default:
                begin
                    enq_weight = 35;
                    deq_weight = 35;
                end
            endcase
            pick = $urandom_range(0, 99);
            if (pick < enq_weight)
                kind = OP_ENQ;
            else if (pick < enq_weight + deq_weight)
                kind = OP_DEQ;
            else if (pick < 95)
                kind = OP_PEEK;
            else
                kind = OP_NOP;

            // half the priorities from a few values so ties are common
            if ($urandom_range(0, 1) == 0)
                pri = 8'($urandom_range(0, 3) * 85);
            else
                pri = 8'($urandom_range(0, 255));
            send_op(kind, pri, $urandom(), 1'b0, '0);
        end

        // wait out the tail, then keep the clock running for stray words
        drain_pending();
        repeat (4)
            @(posedge clk);

        $display("ran %0d words: %0d enqueues taken, %0d refused full; %0d dequeues, %0d on empty",
                 DIRECTED_ROWS + RANDOM_ITEMS, enq_done, enq_refused, deq_done, deq_refused);
        $display("peeks %0d with head, %0d on empty; %0d unused codes; deepest fill %0d of %0d",
                 peek_hit, peek_refused, nop_count, deepest, CAPACITY);
        if (fail_count == 0)
            $display("stable_priority_queue_tb: done, clean");
        else
            $display("stable_priority_queue_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+sv
sv/spq_pkg.sv
sv/spq_if.sv
sv/spq_cell.sv
sv/stable_priority_queue.sv
sv/spq_checker.sv
tb/stable_priority_queue_tb.sv
